// File: src/device_permission_table_top_defines.svh
// assertion macros used by the checker file
`ifndef DEVICE_PERMISSION_TABLE_TOP_DEFINES_SVH
`define DEVICE_PERMISSION_TABLE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dpt_pkg.sv
// types and constants of the device permission table
package dpt_pkg;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // default modes on a read miss
    localparam logic [15:0] DEF_DIR_MODE   = 16'o755;
    localparam logic [15:0] DEF_FILE_MODE  = 16'o666;
    localparam logic [15:0] DEF_BLOCK_MODE = 16'o600;

    typedef struct packed {
        logic        mode;
        logic [31:0] cluster_key;
        logic [31:0] volume_key;
        logic        is_directory;
        logic        is_block_device;
        logic [15:0] perm_bits_in;
        logic [31:0] owner_in;
        logic [31:0] group_in;
    } req_t;

    typedef struct packed {
        logic        status;
        logic        hit;
        logic [15:0] perm_bits_out;
        logic [31:0] owner_out;
        logic [31:0] group_out;
    } rsp_t;

    // one stored record, key and payload in a single memory word
    typedef struct packed {
        logic [31:0] cluster;
        logic [31:0] volume;
        logic [15:0] perm_bits;
        logic [31:0] owner;
        logic [31:0] group;
    } entry_t;

endpackage

// File: src/dpt_stream_if.sv
// valid/ready stream channel with a typed payload
interface dpt_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/dpt_ram.sv
// generic single-clock ram, one write port, one registered read port
module dpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/dpt_ctrl.sv
// scan sequencer: walks the filled entries, then answers a read or updates or appends, refusing a new key when full
module dpt_ctrl #(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dpt_pkg::req_t req_data,
    output logic          res_valid,
    input  logic          res_ready,
    output dpt_pkg::rsp_t res_data
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    dpt_pkg::req_t   req_reg;
    dpt_pkg::rsp_t   res_reg, res_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   scan_idx_reg;
    logic            cmp_vld_reg;
    logic [AW-1:0]   cmp_idx_reg;

    dpt_pkg::entry_t rd_entry, wr_entry;
    logic            issue, key_match, scan_end, full, wr_en;
    logic [AW-1:0]   wr_addr;
    logic [15:0]     def_mode;

    // entries are only appended, so the valid ones are always 0..count-1
    assign issue     = (state_reg == ST_SCAN) && (scan_idx_reg < count_reg);
    assign key_match = cmp_vld_reg && (rd_entry.cluster == req_reg.cluster_key)
                       && (rd_entry.volume == req_reg.volume_key);
    assign scan_end  = (state_reg == ST_SCAN) && (key_match || !issue);
    assign full      = (count_reg == CW'(TABLE_ENTRIES));

    assign wr_en   = scan_end && (req_reg.mode == dpt_pkg::OP_WRITE) && (key_match || !full);
    assign wr_addr = key_match ? cmp_idx_reg : count_reg[AW-1:0];

    always_comb
    begin
        wr_entry.cluster   = req_reg.cluster_key;
        wr_entry.volume    = req_reg.volume_key;
        wr_entry.perm_bits = req_reg.perm_bits_in;
        wr_entry.owner     = req_reg.owner_in;
        wr_entry.group     = req_reg.group_in;
    end

    dpt_ram #(
        .WIDTH ($bits(dpt_pkg::entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[AW-1:0]),
        .rd_data (rd_entry)
    );

    always_comb
    begin
        if (req_reg.is_block_device)
        begin
            def_mode = dpt_pkg::DEF_BLOCK_MODE;
        end
        else if (req_reg.is_directory)
        begin
            def_mode = dpt_pkg::DEF_DIR_MODE;
        end
        else
        begin
            def_mode = dpt_pkg::DEF_FILE_MODE;
        end
    end

    always_comb
    begin
        res_next.hit = key_match;
        count_next   = count_reg;
        if (req_reg.mode == dpt_pkg::OP_WRITE)
        begin
            res_next.status        = (!key_match && full) ? dpt_pkg::STATUS_FULL
                                                          : dpt_pkg::STATUS_OK;
            res_next.perm_bits_out = req_reg.perm_bits_in;
            res_next.owner_out     = req_reg.owner_in;
            res_next.group_out     = req_reg.group_in;
            if (!key_match && !full)
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (key_match)
        begin
            res_next.status        = dpt_pkg::STATUS_OK;
            res_next.perm_bits_out = rd_entry.perm_bits;
            res_next.owner_out     = rd_entry.owner;
            res_next.group_out     = rd_entry.group;
        end
        else
        begin
            res_next.status        = dpt_pkg::STATUS_OK;
            res_next.perm_bits_out = def_mode;
            res_next.owner_out     = '0;
            res_next.group_out     = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
            begin
                scan_idx_reg <= '0;
                cmp_vld_reg  <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
                cmp_vld_reg <= issue && !scan_end;
                if (scan_end)
                begin
                    count_reg <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req_data;
        end
        if (issue)
        begin
            cmp_idx_reg <= scan_idx_reg[AW-1:0];
        end
        if (scan_end)
        begin
            res_reg <= res_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_data  = res_reg;

endmodule

// File: src/dpt_out_reg.sv
// output register between the sequencer and the result channel
module dpt_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    output logic          res_ready,
    input  dpt_pkg::rsp_t res_data,
    output logic          out_valid,
    input  logic          out_ready,
    output dpt_pkg::rsp_t out_data
);

    logic          valid_reg;
    dpt_pkg::rsp_t data_reg;

    assign res_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/device_permission_table_top.sv
// top level of the device permission table
// usage
//   req carries one request per transfer: mode 0 reads the record of a key
//   (cluster_key, volume_key), mode 1 writes perm_bits_in, owner_in, group_in
//   under that key. rsp carries exactly one result per request, in order.
//   a read miss returns the default mode (0600 block device, 0755 directory,
//   else 0666) with owner and group 0 and stores nothing. a write updates
//   the matching entry or appends at the next free slot; with all
//   TABLE_ENTRIES slots taken a write of a new key returns status 1.
// storage and scan
//   records sit in one ram of TABLE_ENTRIES words with a registered read;
//   the sequencer reads one stored entry per cycle and stops at a match.
//   a request is scanned over the filled entries, and the next request is
//   taken only after the result of this one has moved to the output register.
// reset: rst_n clears the fill count, so the table is empty at once; the ram
//   is not cleared and needs no sweep, a request can follow right away.
// stalls: a result waits in the output register while rsp.ready is low; the
//   next request is still taken and scanned, and holds only at its own result.
module device_permission_table_top #(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    dpt_stream_if.sink   req,
    dpt_stream_if.source rsp
);

    dpt_pkg::req_t req_data;
    dpt_pkg::rsp_t res_data;
    dpt_pkg::rsp_t out_data;
    logic          res_valid;
    logic          res_ready;

    assign req_data = req.data;

    // scan and update sequencer around the record ram
    dpt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // decouples the result channel from the sequencer
    dpt_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (out_data)
    );

    assign rsp.data = out_data;

endmodule

// File: src/dpt_checker.sv
// port-level checker for the device permission table and its bind
`include "device_permission_table_top_defines.svh"

module dpt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input dpt_pkg::rsp_t rsp_data
);

    logic [1:0] pending_reg;
    logic       req_xfer, rsp_xfer, rsp_stall, rsp_full;

    assign req_xfer  = req_valid && req_ready;
    assign rsp_xfer  = rsp_valid && rsp_ready;
    assign rsp_stall = rsp_valid && !rsp_ready;
    assign rsp_full  = rsp_valid && (rsp_data.status == dpt_pkg::STATUS_FULL);

    // requests taken minus results delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(req_xfer) - 2'(rsp_xfer);
        end
    end

    `DPT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "stalled result moved")
    `DPT_ASSERT_NOW(a_no_orphan, rsp_valid, pending_reg != 2'd0, "result without a request")
    `DPT_ASSERT_NOW(a_bounded, 1'b1, pending_reg != 2'd3, "too many requests in flight")
    `DPT_ASSERT_NOW(a_full_miss, rsp_full, !rsp_data.hit, "table full reported on a hit")

endmodule

bind device_permission_table_top dpt_checker u_dpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// File: tb/sv/tb_top.sv
// self-checking testbench of the device permission table: directed and random requests
module tb_top;

    localparam int TABLE_ENTRIES = 128;

    // default modes on a read miss
    localparam logic [15:0] BLOCK_MISS_MODE = 16'o600;
    localparam logic [15:0] DIR_MISS_MODE   = 16'o755;
    localparam logic [15:0] FILE_MISS_MODE  = 16'o666;

    // drain margin, enough to cover any result in flight
    localparam int DRAIN_CYCLES = TABLE_ENTRIES + 16;

    logic clk;
    logic rst_n;

    dpt_stream_if #(.payload_t(dpt_pkg::req_t)) req_ch ();
    dpt_stream_if #(.payload_t(dpt_pkg::rsp_t)) rsp_ch ();

    device_permission_table_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // shadow copy of the permission table, filled lowest slot first
    bit          shadow_valid   [TABLE_ENTRIES];
    logic [31:0] shadow_cluster [TABLE_ENTRIES];
    logic [31:0] shadow_volume  [TABLE_ENTRIES];
    logic [15:0] shadow_perm    [TABLE_ENTRIES];
    logic [31:0] shadow_owner   [TABLE_ENTRIES];
    logic [31:0] shadow_group   [TABLE_ENTRIES];
    int          shadow_fill;

    // results still owed by the block, oldest first
    dpt_pkg::rsp_t pending_results[$];
    dpt_pkg::rsp_t oldest_result;

    // idle chances in percent per cycle, changed from phase to phase
    int send_idle_pct;
    int recv_idle_pct;

    int fail_count;
    int read_count;
    int write_count;
    int hit_count;
    int full_count;

    // clock, period 10
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // every input known from time zero
    initial
    begin
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
    end

    // receiver side: ready drops at random on each falling edge
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // lookup and update of the shadow table for one accepted request
    function automatic dpt_pkg::rsp_t lookup_permission(input dpt_pkg::req_t r);
        dpt_pkg::rsp_t res;
        int   match_idx;
        int   free_idx;
        int   i;
        match_idx = -1;
        free_idx  = -1;
        for (i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (!shadow_valid[i])
            begin
                if (free_idx < 0)
                    free_idx = i;
            end
            else if (match_idx < 0 && shadow_cluster[i] == r.cluster_key &&
                     shadow_volume[i] == r.volume_key)
                match_idx = i;
        end

        res.status = dpt_pkg::STATUS_OK;
        res.hit    = (match_idx >= 0);
        if (r.mode == dpt_pkg::OP_READ)
        begin
            read_count++;
            if (match_idx >= 0)
            begin
                res.perm_bits_out = shadow_perm[match_idx];
                res.owner_out     = shadow_owner[match_idx];
                res.group_out     = shadow_group[match_idx];
            end
            else
            begin
                // block device wins over directory
                if (r.is_block_device)
                    res.perm_bits_out = BLOCK_MISS_MODE;
                else if (r.is_directory)
                    res.perm_bits_out = DIR_MISS_MODE;
                else
                    res.perm_bits_out = FILE_MISS_MODE;
                res.owner_out = '0;
                res.group_out = '0;
            end
        end
        else
        begin
            write_count++;
            // a write always echoes its payload
            res.perm_bits_out = r.perm_bits_in;
            res.owner_out     = r.owner_in;
            res.group_out     = r.group_in;
            if (match_idx >= 0)
            begin
                shadow_perm[match_idx]  = r.perm_bits_in;
                shadow_owner[match_idx] = r.owner_in;
                shadow_group[match_idx] = r.group_in;
            end
            else if (free_idx >= 0)
            begin
                shadow_valid[free_idx]   = 1'b1;
                shadow_cluster[free_idx] = r.cluster_key;
                shadow_volume[free_idx]  = r.volume_key;
                shadow_perm[free_idx]    = r.perm_bits_in;
                shadow_owner[free_idx]   = r.owner_in;
                shadow_group[free_idx]   = r.group_in;
                shadow_fill++;
            end
            else
            begin
                res.status = dpt_pkg::STATUS_FULL;
                full_count++;
            end
        end
        if (res.hit)
            hit_count++;
        return res;
    endfunction

    function automatic dpt_pkg::req_t make_request(input logic op, input logic [31:0] ckey,
                                                   input logic [31:0] vkey, input logic dir,
                                                   input logic blk, input logic [15:0] perm,
                                                   input logic [31:0] own,
                                                   input logic [31:0] grp);
        dpt_pkg::req_t r;
        r.mode            = op;
        r.cluster_key     = ckey;
        r.volume_key      = vkey;
        r.is_directory    = dir;
        r.is_block_device = blk;
        r.perm_bits_in    = perm;
        r.owner_in        = own;
        r.group_in        = grp;
        return r;
    endfunction

    // key word with a bias toward the extremes
    function automatic logic [31:0] random_key_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 32'h0000_0000;
        else if (pick == 1)
            return 32'hFFFF_FFFF;
        else
            return $urandom;
    endfunction

    // random request: stored keys most often, then fresh keys, then near misses
    function automatic dpt_pkg::req_t random_request();
        dpt_pkg::req_t r;
        int   pick;
        int   idx;
        int   flip;
        r = make_request(1'($urandom_range(0, 1)), random_key_word(), random_key_word(),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         16'($urandom), $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (shadow_fill > 0 && pick < 70)
        begin
            // entries are filled from slot 0 upward and never removed
            idx = $urandom_range(0, shadow_fill - 1);
            r.cluster_key = shadow_cluster[idx];
            r.volume_key  = shadow_volume[idx];
            if (pick >= 50)
            begin
                // near miss: one key bit flipped, in either half of the key
                flip = $urandom_range(0, 63);
                if (flip < 32)
                    r.cluster_key[flip] = ~r.cluster_key[flip];
                else
                    r.volume_key[flip - 32] = ~r.volume_key[flip - 32];
            end
        end
        return r;
    endfunction

    // one request transfer; called and left at a falling edge, valid stays
    // high into the next call so that back-to-back transfers carry no gap
    task automatic send_request(input dpt_pkg::req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(lookup_permission(item));
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // result side: every transfer on rsp is compared with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no request outstanding: %0h", rsp_ch.data);
                fail_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("status", 32'(oldest_result.status), 32'(rsp_ch.data.status));
                check_field("hit", 32'(oldest_result.hit), 32'(rsp_ch.data.hit));
                check_field("perm_bits_out", 32'(oldest_result.perm_bits_out),
                            32'(rsp_ch.data.perm_bits_out));
                check_field("owner_out", oldest_result.owner_out, rsp_ch.data.owner_out);
                check_field("group_out", oldest_result.group_out, rsp_ch.data.group_out);
            end
        end
    end

    // misses on the empty table: every default mode, extreme keys, payload ignored
    task automatic test_read_defaults();
        send_request(make_request(dpt_pkg::OP_READ, 32'h0, 32'h0, 1'b0, 1'b0,
                                  16'h0, 32'h0, 32'h0));
        send_request(make_request(dpt_pkg::OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0,
                                  16'h0, 32'h0, 32'h0));
        send_request(make_request(dpt_pkg::OP_READ, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1,
                                  16'h0, 32'h0, 32'h0));
        send_request(make_request(dpt_pkg::OP_READ, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1,
                                  16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    // inserts, read hits, an update in place and misses on half-matching keys
    task automatic test_write_update();
        send_request(make_request(dpt_pkg::OP_WRITE, 32'h0, 32'h0, 1'b1, 1'b1,
                                  16'h0, 32'h0, 32'h0));
        send_request(make_request(dpt_pkg::OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0,
                                  16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_request(dpt_pkg::OP_READ, 32'h0, 32'h0, 1'b1, 1'b0,
                                  16'h0, 32'h0, 32'h0));
        send_request(make_request(dpt_pkg::OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1,
                                  16'h0, 32'h0, 32'h0));
        send_request(make_request(dpt_pkg::OP_WRITE, 32'h0, 32'h0, 1'b0, 1'b0, 16'o4755,
                                  32'd1000, 32'd100));
        send_request(make_request(dpt_pkg::OP_READ, 32'h0, 32'h0, 1'b0, 1'b0,
                                  16'h0, 32'h0, 32'h0));
        // only one half of the key matches a stored entry
        send_request(make_request(dpt_pkg::OP_READ, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1,
                                  16'h0, 32'h0, 32'h0));
        send_request(make_request(dpt_pkg::OP_READ, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0,
                                  16'h0, 32'h0, 32'h0));
        send_request(make_request(dpt_pkg::OP_WRITE, 32'h1, 32'h0, 1'b0, 1'b0, 16'h8000,
                                  32'h8000_0000, 32'h0000_0001));
        send_request(make_request(dpt_pkg::OP_READ, 32'h1, 32'h0, 1'b1, 1'b1,
                                  16'h0, 32'h0, 32'h0));
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        int n;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (n = 0; n < count; n++)
            send_request(random_request());
    endtask

    // fill every free slot, then new keys must be refused while updates still land
    task automatic test_table_full();
        while (shadow_fill < TABLE_ENTRIES)
            send_request(make_request(dpt_pkg::OP_WRITE, $urandom, $urandom,
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      16'($urandom), $urandom, $urandom));
        repeat (3)
            send_request(make_request(dpt_pkg::OP_WRITE, $urandom, $urandom, 1'b0, 1'b0,
                                      16'($urandom), $urandom, $urandom));
        // update of the last slot and a read of it, both at the far end of the scan
        send_request(make_request(dpt_pkg::OP_WRITE, shadow_cluster[TABLE_ENTRIES - 1],
                                  shadow_volume[TABLE_ENTRIES - 1], 1'b0, 1'b0,
                                  16'h1234, 32'hCAFE_0001, 32'h0BAD_0002));
        send_request(make_request(dpt_pkg::OP_READ, shadow_cluster[TABLE_ENTRIES - 1],
                                  shadow_volume[TABLE_ENTRIES - 1], 1'b1, 1'b1,
                                  16'h0, 32'h0, 32'h0));
        send_request(make_request(dpt_pkg::OP_READ, $urandom, $urandom, 1'b1, 1'b0,
                                  16'h0, 32'h0, 32'h0));
    endtask

    // main sequence
    initial
    begin
        shadow_fill   = 0;
        fail_count    = 0;
        read_count    = 0;
        write_count   = 0;
        hit_count     = 0;
        full_count    = 0;
        send_idle_pct = 32;
        recv_idle_pct = 60;

        // reset held low, then released on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_read_defaults();
        test_write_update();
        // sender idles lightly, receiver heavily
        test_random_traffic(410, 32, 60);
        // the other way round
        test_random_traffic(410, 60, 32);
        test_table_full();
        // no idles on either side, on a full table
        test_random_traffic(410, 0, 0);

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d reads and %0d writes: %0d key hits, %0d refused on a full table",
                 read_count, write_count, hit_count, full_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #8000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
